// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp assertion failed");

// Next-cycle implication, checked outside reset.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp assertion failed");

`endif

// ===== src/hrp_pkg.sv =====
// Types, character codes and helpers of the HTTP response head parser.
package hrp_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_T     = 8'd84;
    localparam logic [7:0] CH_P     = 8'd80;

    localparam logic [9:0] LEGACY_STATUS = 10'd200;

    typedef enum logic [1:0] {
        OUTCOME_HEAD_END  = 2'd0,
        OUTCOME_NO_PREFIX = 2'd1,
        OUTCOME_STREAM_END = 2'd2
    } outcome_t;

    typedef enum logic [11:0] {
        PH_PREFIX0 = 12'b0000_0000_0001,
        PH_PREFIX1 = 12'b0000_0000_0010,
        PH_PREFIX2 = 12'b0000_0000_0100,
        PH_PREFIX3 = 12'b0000_0000_1000,
        PH_AFTER   = 12'b0000_0001_0000,
        PH_MAJOR   = 12'b0000_0010_0000,
        PH_MINOR   = 12'b0000_0100_0000,
        PH_SKIP    = 12'b0000_1000_0000,
        PH_DIGIT2  = 12'b0001_0000_0000,
        PH_DIGIT3  = 12'b0010_0000_0000,
        PH_GOOD    = 12'b0100_0000_0000,
        PH_BAD     = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        outcome_t    outcome;
        logic        status_valid;
        logic [9:0]  status_code;
        logic [15:0] head_length;
        logic [7:0]  header_lines;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'd48) && (b <= 8'd57);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SP) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

endpackage

// ===== src/hrp_channels.sv =====
// Byte and result channel interfaces of the head parser.
interface hrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface hrp_result_if;
    logic              valid;
    logic              ready;
    hrp_pkg::outcome_t outcome;
    logic              status_valid;
    logic [9:0]        status_code;
    logic [15:0]       head_length;
    logic [7:0]        header_lines;

    modport source (output valid, output outcome, output status_valid,
                    output status_code, output head_length, output header_lines,
                    input ready);
    modport sink (input valid, input outcome, input status_valid,
                  input status_code, input head_length, input header_lines,
                  output ready);
endinterface

// ===== src/http_response_head_parser_unit.sv =====
// HTTP response head parser: byte stream in, one summary word per response out.
//
// byte_ch carries the response one byte per word, with last on the final byte.
// result_ch gives at most one word per response: head end found, no HTTP
// prefix (status 200 reported at once), or stream ended before the head end.
// Bytes after a result are dropped until last; after last all parse state
// returns to its reset value, so the next byte starts a new response.
// Throughput: one byte per cycle while the skid register is empty; the parse step
// is combinational between the input register and the result register.
// A taken byte waits in the input register and is parsed from there; its result
// word goes to the output register, or to the skid register while that is full.
// When result_ch stalls, one result waits in the output register and a
// second in the skid register; byte_ch.ready drops only when both are full
// and a byte is waiting in the input register.
// Reset (rst_n low, asynchronous) empties all registers and clears the
// parse state; no clearing pass follows.
// LENGTH_BITS sets the byte position counter; head_length saturates at
// 2^LENGTH_BITS-1 and at 65535.
`include "assert_macros.svh"

module http_response_head_parser_unit #(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    hrp_byte_if.sink            byte_ch,
    hrp_result_if.source        result_ch
);

    localparam int WIDE_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    // input register
    logic            in_valid_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;

    // parse state
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [7:0]      prev_reg, prev_next;
    logic [7:0]      prev2_reg, prev2_next;
    hrp_pkg::phase_t phase_reg, phase_next;
    logic [9:0]      acc_reg, acc_next;
    logic [7:0]      lines_reg, lines_next;
    logic            line_start_reg, line_start_next;
    logic            given_reg, given_next;

    // output register and skid register
    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    hrp_pkg::result_t out_reg;
    hrp_pkg::result_t skid_reg;

    hrp_pkg::result_t res;
    logic            res_valid;
    logic            fire;
    logic            out_take;
    logic            in_take;

    // combinational helpers
    logic [LENGTH_BITS-1:0] len;
    logic [WIDE_BITS-1:0]   len_wide;
    logic [15:0]     head_len;
    logic [7:0]      expected;
    logic            in_prefix;
    logic            prefix_fail;
    logic            skip_path;
    logic [9:0]      acc_times10;
    logic            inc_line;
    logic            inc_tail;
    logic            terminator;
    logic [7:0]      lines_a;
    logic [7:0]      lines_b;
    logic            good_next;

    assign fire     = in_valid_reg && !skid_valid_reg;
    assign out_take = out_valid_reg && result_ch.ready;
    assign byte_ch.ready = !(in_valid_reg && skid_valid_reg);
    assign in_take  = byte_ch.valid && byte_ch.ready;

    assign len      = (pos_reg != {LENGTH_BITS{1'b1}}) ? pos_reg + 1'b1 : pos_reg;
    assign len_wide = WIDE_BITS'(len);
    assign head_len = (len_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];

    assign acc_times10 = {acc_reg[6:0], 3'b000} + {acc_reg[8:0], 1'b0};

    always_comb
    begin
        in_prefix = 1'b1;
        case (phase_reg)
            hrp_pkg::PH_PREFIX0: expected = hrp_pkg::CH_H;
            hrp_pkg::PH_PREFIX1: expected = hrp_pkg::CH_T;
            hrp_pkg::PH_PREFIX2: expected = hrp_pkg::CH_T;
            hrp_pkg::PH_PREFIX3: expected = hrp_pkg::CH_P;
            default:
            begin
                expected  = 8'd0;
                in_prefix = 1'b0;
            end
        endcase
        prefix_fail = in_prefix && (byte_reg != expected);
    end

    // version, white space and status digits
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        skip_path  = 1'b0;
        case (phase_reg)
            hrp_pkg::PH_PREFIX0: phase_next = hrp_pkg::PH_PREFIX1;
            hrp_pkg::PH_PREFIX1: phase_next = hrp_pkg::PH_PREFIX2;
            hrp_pkg::PH_PREFIX2: phase_next = hrp_pkg::PH_PREFIX3;
            hrp_pkg::PH_PREFIX3: phase_next = hrp_pkg::PH_AFTER;
            hrp_pkg::PH_AFTER:
            begin
                if (byte_reg == hrp_pkg::CH_SLASH)
                    phase_next = hrp_pkg::PH_MAJOR;
                else
                    skip_path = 1'b1;
            end
            hrp_pkg::PH_MAJOR:
            begin
                if (hrp_pkg::is_digit(byte_reg))
                    phase_next = hrp_pkg::PH_MAJOR;
                else if (byte_reg == hrp_pkg::CH_DOT)
                    phase_next = hrp_pkg::PH_MINOR;
                else
                    skip_path = 1'b1;
            end
            hrp_pkg::PH_MINOR:
            begin
                if (hrp_pkg::is_digit(byte_reg))
                    phase_next = hrp_pkg::PH_MINOR;
                else
                    skip_path = 1'b1;
            end
            hrp_pkg::PH_SKIP: skip_path = 1'b1;
            hrp_pkg::PH_DIGIT2:
            begin
                if (hrp_pkg::is_digit(byte_reg))
                begin
                    phase_next = hrp_pkg::PH_DIGIT3;
                    acc_next   = acc_times10 + {6'd0, byte_reg[3:0]};
                end
                else
                    phase_next = hrp_pkg::PH_BAD;
            end
            hrp_pkg::PH_DIGIT3:
            begin
                if (hrp_pkg::is_digit(byte_reg))
                begin
                    phase_next = hrp_pkg::PH_GOOD;
                    acc_next   = acc_times10 + {6'd0, byte_reg[3:0]};
                end
                else
                    phase_next = hrp_pkg::PH_BAD;
            end
            default: phase_next = phase_reg;
        endcase
        if (skip_path)
        begin
            if (hrp_pkg::is_space(byte_reg))
                phase_next = hrp_pkg::PH_SKIP;
            else if (hrp_pkg::is_digit(byte_reg))
            begin
                phase_next = hrp_pkg::PH_DIGIT2;
                acc_next   = {6'd0, byte_reg[3:0]};
            end
            else
                phase_next = hrp_pkg::PH_BAD;
        end
    end

    // line counting and end-of-head detection
    always_comb
    begin
        if (line_start_reg)
            inc_line = (byte_reg != hrp_pkg::CH_SP) && (byte_reg != hrp_pkg::CH_TAB)
                    && (byte_reg != hrp_pkg::CH_CR) && (byte_reg != hrp_pkg::CH_LF);
        else
            inc_line = (prev_reg == hrp_pkg::CH_CR) && (prev2_reg == hrp_pkg::CH_LF)
                    && (byte_reg != hrp_pkg::CH_LF);
        terminator = (byte_reg == hrp_pkg::CH_LF)
                  && ((prev_reg == hrp_pkg::CH_LF)
                   || ((prev_reg == hrp_pkg::CH_CR) && (prev2_reg == hrp_pkg::CH_LF)));
        // a final CR right after LF still opens a line
        inc_tail = !terminator && last_reg && (byte_reg == hrp_pkg::CH_CR)
                && (prev_reg == hrp_pkg::CH_LF);
        lines_a  = (inc_line && (lines_reg != 8'hFF)) ? lines_reg + 8'd1 : lines_reg;
        lines_b  = (inc_tail && (lines_a != 8'hFF)) ? lines_a + 8'd1 : lines_a;
        good_next = (phase_next == hrp_pkg::PH_GOOD);
    end

    // result word and state update for the byte in the input register
    always_comb
    begin
        res_valid         = 1'b0;
        res.outcome       = hrp_pkg::OUTCOME_HEAD_END;
        res.status_valid  = 1'b0;
        res.status_code   = 10'd0;
        res.head_length   = head_len;
        res.header_lines  = lines_a;

        pos_next        = pos_reg;
        prev_next       = prev_reg;
        prev2_next      = prev2_reg;
        lines_next      = lines_reg;
        line_start_next = line_start_reg;
        given_next      = given_reg;

        if (!given_reg)
        begin
            if (prefix_fail)
            begin
                res_valid        = 1'b1;
                res.outcome      = hrp_pkg::OUTCOME_NO_PREFIX;
                res.status_valid = 1'b1;
                res.status_code  = hrp_pkg::LEGACY_STATUS;
                res.head_length  = 16'd0;
                res.header_lines = 8'd0;
                given_next       = 1'b1;
            end
            else
            begin
                if (terminator)
                begin
                    res_valid        = 1'b1;
                    res.outcome      = hrp_pkg::OUTCOME_HEAD_END;
                    res.status_valid = good_next;
                    res.status_code  = good_next ? acc_next : 10'd0;
                    given_next       = 1'b1;
                end
                else if (last_reg)
                begin
                    res_valid        = 1'b1;
                    res.outcome      = hrp_pkg::OUTCOME_STREAM_END;
                    res.status_valid = good_next && (byte_reg == hrp_pkg::CH_LF);
                    res.status_code  = res.status_valid ? acc_next : 10'd0;
                    res.header_lines = lines_b;
                    given_next       = 1'b1;
                end
                pos_next        = len;
                prev_next       = byte_reg;
                prev2_next      = prev_reg;
                lines_next      = lines_a;
                line_start_next = (byte_reg == hrp_pkg::CH_LF);
            end
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_next = 1'b0;
        end
        else if (fire && res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_next = 1'b1;
            else
                skid_valid_next = 1'b1;
        end
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            pos_reg        <= '0;
            prev_reg       <= 8'd0;
            prev2_reg      <= 8'd0;
            phase_reg      <= hrp_pkg::PH_PREFIX0;
            acc_reg        <= 10'd0;
            lines_reg      <= 8'd0;
            line_start_reg <= 1'b1;
            given_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (fire)
            begin
                if (last_reg)
                begin
                    // end of response: start over
                    pos_reg        <= '0;
                    prev_reg       <= 8'd0;
                    prev2_reg      <= 8'd0;
                    phase_reg      <= hrp_pkg::PH_PREFIX0;
                    acc_reg        <= 10'd0;
                    lines_reg      <= 8'd0;
                    line_start_reg <= 1'b1;
                    given_reg      <= 1'b0;
                end
                else
                begin
                    pos_reg        <= pos_next;
                    prev_reg       <= prev_next;
                    prev2_reg      <= prev2_next;
                    lines_reg      <= lines_next;
                    line_start_reg <= line_start_next;
                    given_reg      <= given_next;
                    if (!given_reg && !prefix_fail)
                    begin
                        phase_reg <= phase_next;
                        acc_reg   <= acc_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= byte_ch.data_byte;
            last_reg <= byte_ch.last;
        end
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (fire && res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.outcome      = out_reg.outcome;
    assign result_ch.status_valid = out_reg.status_valid;
    assign result_ch.status_code  = out_reg.status_code;
    assign result_ch.head_length  = out_reg.head_length;
    assign result_ch.header_lines = out_reg.header_lines;

    `HRP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `HRP_ASSERT_NEXT(a_stall_to_skid, clk, rst_n,
        fire && res_valid && out_valid_reg && !result_ch.ready, skid_valid_reg)
    `HRP_ASSERT_SAME(a_one_result, clk, rst_n, fire && given_reg, !res_valid)
    `HRP_ASSERT_NEXT(a_last_restarts, clk, rst_n, fire && last_reg,
        (phase_reg == hrp_pkg::PH_PREFIX0) && (pos_reg == '0) && !given_reg)

endmodule

// ===== verif/tb_http_response_head_parser_unit.sv =====
// Testbench of the HTTP response head parser: random and directed byte streams, scored per word.
`timescale 1ns / 100ps

module tb_http_response_head_parser_unit;

    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam int unsigned POSITION_LIMIT =
        (32'd1 << hrp_pkg::LENGTH_BITS_DEFAULT) - 32'd1;

    class head_summary_board;
        hrp_pkg::result_t expected_summaries[$];
        int               failures;
        int unsigned      position;
        logic [7:0]       prev_byte;
        logic [7:0]       prev2_byte;
        hrp_pkg::phase_t  phase;
        logic [9:0]       code_acc;
        logic [7:0]       line_count;
        bit               at_line_start;
        bit               summary_out;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            position      = 0;
            prev_byte     = 8'd0;
            prev2_byte    = 8'd0;
            phase         = hrp_pkg::PH_PREFIX0;
            code_acc      = 10'd0;
            line_count    = 8'd0;
            at_line_start = 1'b1;
            summary_out   = 1'b0;
        endfunction

        function bit digit_char(logic [7:0] b);
            return b >= CH_ZERO && b <= 8'd57;
        endfunction

        function void bump_lines();
            if (line_count != 8'd255)
                line_count++;
        endfunction

        function void expect_summary(hrp_pkg::outcome_t o, bit ok, logic [9:0] code,
                                     int unsigned len, logic [7:0] lines);
            hrp_pkg::result_t r;
            r.outcome      = o;
            r.status_valid = ok;
            r.status_code  = ok ? code : 10'd0;
            r.head_length  = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
            r.header_lines = lines;
            expected_summaries.push_back(r);
            summary_out = 1'b1;
        endfunction

        // Version, blank skip and the three status digits, in that order.
        function hrp_pkg::phase_t step_phase(hrp_pkg::phase_t p, logic [7:0] b);
            hrp_pkg::phase_t q;
            q = p;
            if (q == hrp_pkg::PH_AFTER)
            begin
                if (b == hrp_pkg::CH_SLASH)
                    return hrp_pkg::PH_MAJOR;
                q = hrp_pkg::PH_SKIP;
            end
            if (q == hrp_pkg::PH_MAJOR)
            begin
                if (digit_char(b))
                    return hrp_pkg::PH_MAJOR;
                if (b == hrp_pkg::CH_DOT)
                    return hrp_pkg::PH_MINOR;
                q = hrp_pkg::PH_SKIP;
            end
            if (q == hrp_pkg::PH_MINOR)
            begin
                if (digit_char(b))
                    return hrp_pkg::PH_MINOR;
                q = hrp_pkg::PH_SKIP;
            end
            if (q == hrp_pkg::PH_SKIP)
            begin
                if (b == hrp_pkg::CH_SP || (b >= 8'd9 && b <= 8'd13))
                    return hrp_pkg::PH_SKIP;
                if (!digit_char(b))
                    return hrp_pkg::PH_BAD;
                code_acc = {2'b00, b - CH_ZERO};
                return hrp_pkg::PH_DIGIT2;
            end
            if (q == hrp_pkg::PH_DIGIT2 || q == hrp_pkg::PH_DIGIT3)
            begin
                if (!digit_char(b))
                    return hrp_pkg::PH_BAD;
                code_acc = code_acc * 10'd10 + {2'b00, b - CH_ZERO};
                return (q == hrp_pkg::PH_DIGIT2) ? hrp_pkg::PH_DIGIT3 : hrp_pkg::PH_GOOD;
            end
            return q;
        endfunction

        function void take_byte(logic [7:0] b, bit lst);
            int unsigned len;
            logic [7:0]  want;
            bit          ok;
            len = (position < POSITION_LIMIT) ? position + 1 : POSITION_LIMIT;
            if (!summary_out)
            begin
                if (phase inside {hrp_pkg::PH_PREFIX0, hrp_pkg::PH_PREFIX1,
                                  hrp_pkg::PH_PREFIX2, hrp_pkg::PH_PREFIX3})
                begin
                    case (phase)
                        hrp_pkg::PH_PREFIX0: want = hrp_pkg::CH_H;
                        hrp_pkg::PH_PREFIX3: want = hrp_pkg::CH_P;
                        default:             want = hrp_pkg::CH_T;
                    endcase
                    if (b != want)
                        expect_summary(hrp_pkg::OUTCOME_NO_PREFIX, 1'b1,
                                       hrp_pkg::LEGACY_STATUS, 0, 8'd0);
                    else
                    begin
                        case (phase)
                            hrp_pkg::PH_PREFIX0: phase = hrp_pkg::PH_PREFIX1;
                            hrp_pkg::PH_PREFIX1: phase = hrp_pkg::PH_PREFIX2;
                            hrp_pkg::PH_PREFIX2: phase = hrp_pkg::PH_PREFIX3;
                            default:             phase = hrp_pkg::PH_AFTER;
                        endcase
                    end
                end
                else
                    phase = step_phase(phase, b);
            end
            if (!summary_out)
            begin
                if (at_line_start)
                begin
                    if (!(b inside {hrp_pkg::CH_SP, hrp_pkg::CH_TAB,
                                    hrp_pkg::CH_CR, hrp_pkg::CH_LF}))
                        bump_lines();
                end
                else if (prev_byte == hrp_pkg::CH_CR && prev2_byte == hrp_pkg::CH_LF
                         && b != hrp_pkg::CH_LF)
                    bump_lines();
                if (b == hrp_pkg::CH_LF && (prev_byte == hrp_pkg::CH_LF ||
                    (prev_byte == hrp_pkg::CH_CR && prev2_byte == hrp_pkg::CH_LF)))
                begin
                    ok = (phase == hrp_pkg::PH_GOOD);
                    expect_summary(hrp_pkg::OUTCOME_HEAD_END, ok, code_acc, len, line_count);
                end
                else if (lst)
                begin
                    ok = (phase == hrp_pkg::PH_GOOD) && (b == hrp_pkg::CH_LF);
                    // A line that starts with CR and then ends the stream still counts.
                    if (b == hrp_pkg::CH_CR && prev_byte == hrp_pkg::CH_LF)
                        bump_lines();
                    expect_summary(hrp_pkg::OUTCOME_STREAM_END, ok, code_acc, len,
                                   line_count);
                end
                at_line_start = (b == hrp_pkg::CH_LF);
                prev2_byte    = prev_byte;
                prev_byte     = b;
                position      = len;
            end
            if (lst)
                clear_state();
        endfunction

        function void check_summary(hrp_pkg::result_t got);
            hrp_pkg::result_t want;
            if (expected_summaries.size() == 0)
            begin
                $error("result word with none expected: outcome %0d code %0d length %0d",
                       got.outcome, got.status_code, got.head_length);
                failures++;
                return;
            end
            want = expected_summaries.pop_front();
            if (got.outcome !== want.outcome)
            begin
                $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
                failures++;
            end
            if (got.status_valid !== want.status_valid)
            begin
                $error("status_valid: expected %0d, actual %0d",
                       want.status_valid, got.status_valid);
                failures++;
            end
            if (got.status_code !== want.status_code)
            begin
                $error("status_code: expected %0d, actual %0d",
                       want.status_code, got.status_code);
                failures++;
            end
            if (got.head_length !== want.head_length)
            begin
                $error("head_length: expected %0d, actual %0d",
                       want.head_length, got.head_length);
                failures++;
            end
            if (got.header_lines !== want.header_lines)
            begin
                $error("header_lines: expected %0d, actual %0d",
                       want.header_lines, got.header_lines);
                failures++;
            end
        endfunction

        function int pending();
            return expected_summaries.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hrp_byte_if   byte_ch ();
    hrp_result_if result_ch ();

    http_response_head_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    head_summary_board board = new();

    logic [7:0] resp_q[$];
    bit         tx_quiet;
    bit         rx_quiet;
    int         hold_request;
    int         sent_bytes;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            resp_q.push_back(s[i]);
    endfunction

    function void add_random_text(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                resp_q.push_back(8'($urandom_range(0, 255)));
            else
                resp_q.push_back(8'($urandom_range(33, 126)));
        end
    endfunction

    function void add_digits(int n);
        repeat (n)
            resp_q.push_back(8'($urandom_range(48, 57)));
    endfunction

    function void add_eol();
        if ($urandom_range(0, 1))
            resp_q.push_back(hrp_pkg::CH_CR);
        resp_q.push_back(hrp_pkg::CH_LF);
    endfunction

    function void build_random_response();
        logic [7:0] blanks[7];
        int         kind;
        int         cut;
        blanks = '{hrp_pkg::CH_SP, hrp_pkg::CH_TAB, hrp_pkg::CH_CR, hrp_pkg::CH_LF,
                   8'd11, 8'd12, hrp_pkg::CH_SP};
        resp_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 12))
                resp_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == 1)
        begin
            // Break the prefix at a random spot.
            cut = $urandom_range(0, 3);
            for (int i = 0; i < cut; i++)
                resp_q.push_back(i == 0 ? hrp_pkg::CH_H
                                 : (i == 3 ? hrp_pkg::CH_P : hrp_pkg::CH_T));
            resp_q.push_back(8'($urandom_range(0, 255)));
            add_random_text($urandom_range(0, 6));
            return;
        end
        add_text("HTTP");
        case ($urandom_range(0, 3))
            1: add_text("/1.1");
            2:
            begin
                resp_q.push_back(hrp_pkg::CH_SLASH);
                add_digits($urandom_range(0, 2));
                if ($urandom_range(0, 1))
                begin
                    resp_q.push_back(hrp_pkg::CH_DOT);
                    add_digits($urandom_range(0, 2));
                end
            end
            3: add_text("/2");
            default: ;
        endcase
        repeat ($urandom_range(0, 2))
            resp_q.push_back(blanks[$urandom_range(0, 6)]);
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                resp_q.push_back(8'($urandom_range(65, 90)));
            else if (i < 2 || $urandom_range(0, 9) != 0)
                add_digits(1);
        end
        if ($urandom_range(0, 1))
        begin
            resp_q.push_back(hrp_pkg::CH_SP);
            add_random_text($urandom_range(0, 4));
        end
        add_eol();
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0: resp_q.push_back($urandom_range(0, 1) ? hrp_pkg::CH_SP : hrp_pkg::CH_TAB);
                1:
                begin
                    resp_q.push_back(hrp_pkg::CH_CR);
                    resp_q.push_back(8'($urandom_range(65, 90)));
                end
                default: resp_q.push_back(8'($urandom_range(97, 122)));
            endcase
            add_random_text($urandom_range(1, 6));
            add_eol();
        end
        add_eol();
        repeat ($urandom_range(0, 4))
            resp_q.push_back(8'($urandom_range(0, 255)));
        if (kind == 2)
        begin
            cut = $urandom_range(1, resp_q.size());
            while (resp_q.size() > cut)
                void'(resp_q.pop_back());
        end
    endfunction

    // Leaves valid high after the handshake; a gap before the next word or a drain lowers it.
    task automatic send_byte(logic [7:0] b, bit lst);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last      <= lst;
        do @(posedge clk); while (!byte_ch.ready);
        board.take_byte(b, lst);
        sent_bytes++;
    endtask

    task automatic send_response();
        foreach (resp_q[i])
            send_byte(resp_q[i], i == resp_q.size() - 1);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // Cover a dropped byte still in flight.
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : result_sink
        hrp_pkg::result_t got;
        int               gap;
        bit               hold_done;
        result_ch.ready = 1'b0;
        hold_done       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0 && !hold_done)
            begin
                gap       = hold_request;
                hold_done = 1'b1;
            end
            else
                gap = rx_quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            got.outcome      = result_ch.outcome;
            got.status_valid = result_ch.status_valid;
            got.status_code  = result_ch.status_code;
            got.head_length  = result_ch.head_length;
            got.header_lines = result_ch.header_lines;
            board.check_summary(got);
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'd0;
        byte_ch.last      = 1'b0;
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        hold_request      = 0;
        sent_bytes        = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: NUL then a high byte, a short prefix, a clean CRLF head, a bad status.
        resp_q = '{8'h00, 8'hFF};
        send_response();
        resp_q.delete();
        add_text("HT");
        send_response();
        resp_q.delete();
        add_text("HTTP 404\015\n\015\n");
        send_response();
        resp_q.delete();
        add_text("HTTP 2x\n\n");
        send_response();
        wait_results_done();

        // Hold the result side off while single-byte responses keep coming.
        hold_request = 400;
        resp_q.delete();
        add_text("Z");
        repeat (12)
            send_response();
        wait_results_done();

        // Saturate the line count.
        tx_quiet = 1'b1;
        resp_q.delete();
        add_text("HTTP/1.0 200 OK\015\n");
        repeat (260)
            add_text("a\n");
        add_text("\n\n");
        send_response();
        wait_results_done();

        while (sent_bytes < 1200)
        begin
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = ($urandom_range(0, 5) == 0);
            build_random_response();
            send_response();
            if ($urandom_range(0, 19) == 0)
                wait_results_done();
        end
        wait_results_done();

        if (board.failures == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
